// ----- hdl/kect_pkg.sv -----
// Package for the keyed event counter table: sizes, op codes, command type
// and the one-hot to index encoder used by the front part.
// No dependencies.
package kect_pkg;

   localparam int SLOT_COUNT  = 64;
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int KEY_W       = 32;
   localparam int CNT_W       = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_UPDATE  = 2'd0,
      OP_PUBLISH = 2'd1,
      OP_STALE   = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [SLOT_COUNT-1:0] slot_vec_type;
   typedef logic [KEY_W-1:0]      key_type;
   typedef logic [CNT_W-1:0]      count_type;

   // Classified item handed from the front part to the back part
   typedef struct packed {
      op_type   op;
      logic     dirty;
      logic     found;
      slot_type slot;
   } cmd_type;

   // OR-encode a one-hot (or all-zero) vector into a slot index
   function automatic slot_type onehot_to_slot(slot_vec_type vec);
      slot_type idx;
      idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (vec[i]) begin
            idx = idx | slot_type'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ----- hdl/kect_front.sv -----
// Front part of the keyed event counter table: key match, free-slot claim
// and classification of each item into a command. Uses kect_pkg.
// Holds the slot valid bits and the key cells.
module kect_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  kect_pkg::op_type  req_op,
   input  kect_pkg::key_type req_key,
   input  logic              req_dirty,
   output logic              cmd_push,
   output kect_pkg::cmd_type cmd_data,
   input  logic              cmd_full
);
   import kect_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_ENC  = 2'b10
   } front_state_type;

   front_state_type state_ff, state_in;
   slot_vec_type    used_ff, used_in;
   key_type         key_ff [SLOT_COUNT];
   slot_vec_type    hit_ff, hit_in;
   slot_vec_type    free_ff;
   op_type          op_ff;
   key_type         rkey_ff;
   logic            dirty_ff;

   logic            accept;
   logic            any_hit;
   logic            any_free;
   logic            claim;
   slot_vec_type    free_low;
   slot_type        hit_slot;
   slot_type        free_slot;

   assign req_full = (state_ff != F_IDLE);
   assign accept   = req_push && !req_full;

   // Parallel compare against every occupied slot
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         hit_in[i] = used_ff[i] && (key_ff[i] == req_key);
      end
   end

   // Isolate the lowest free slot
   assign free_low  = free_ff & (~free_ff + slot_vec_type'(1));
   assign any_hit   = |hit_ff;
   assign any_free  = |free_ff;
   assign hit_slot  = onehot_to_slot(hit_ff);
   assign free_slot = onehot_to_slot(free_low);

   assign cmd_push = (state_ff == F_ENC) && !cmd_full;
   assign claim    = cmd_push && (op_ff == OP_UPDATE) && !any_hit && any_free;

   always_comb begin
      cmd_data.op    = op_ff;
      cmd_data.dirty = dirty_ff;
      cmd_data.found = any_hit || claim;
      cmd_data.slot  = any_hit ? hit_slot : free_slot;
   end

   always_comb begin
      used_in = used_ff;
      if (claim) begin
         used_in = used_ff | free_low;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_ENC;
            end
         end
         F_ENC: begin
            if (cmd_push) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff   <= hit_in;
         free_ff  <= ~used_ff;
         op_ff    <= req_op;
         rkey_ff  <= req_key;
         dirty_ff <= req_dirty;
      end
      if (claim) begin
         key_ff[free_slot] <= rkey_ff;
      end
   end

   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_ENC) |-> $onehot0(hit_ff))
      else $error("key matched more than one slot");

   a_claim_grows: assert property (@(posedge clock) disable iff (reset)
      claim |=> ($countones(used_ff) == $countones($past(used_ff)) + 1))
      else $error("claim did not occupy exactly one new slot");

   a_push_in_enc: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> ($past(state_ff) == F_IDLE || $past(state_ff) == F_ENC) &&
                   state_ff == F_ENC)
      else $error("command pushed outside encode state");

endmodule

// ----- hdl/kect_queue.sv -----
// Short command queue between the front and back parts of the keyed event
// counter table. Uses kect_pkg for the command type and depth.
module kect_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kect_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output kect_pkg::cmd_type pop_data,
   output logic              empty
);
   import kect_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

// ----- hdl/kect_back.sv -----
// Back part of the keyed event counter table: counter memories with a
// read-modify-write per command and the result register. Uses kect_pkg.
// Row valid bits stand in for the zero reset of the counter memories.
module kect_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_empty,
   input  kect_pkg::cmd_type   cmd_data,
   output logic                cmd_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic                rsp_found,
   output kect_pkg::count_type rsp_updates,
   output kect_pkg::count_type rsp_dirty,
   output kect_pkg::count_type rsp_publishes,
   output kect_pkg::count_type rsp_stale
);
   import kect_pkg::*;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_RMW  = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   slot_vec_type   row_valid_ff, row_valid_in;
   logic           rd_valid_ff;

   count_type      upd_mem [SLOT_COUNT];
   count_type      drt_mem [SLOT_COUNT];
   count_type      pub_mem [SLOT_COUNT];
   count_type      stl_mem [SLOT_COUNT];
   count_type      upd_rd_ff, drt_rd_ff, pub_rd_ff, stl_rd_ff;

   logic           out_valid_ff, out_valid_in;
   logic           out_found_ff;
   count_type      out_upd_ff, out_drt_ff, out_pub_ff, out_stl_ff;

   logic           load;
   logic           do_write;
   logic           is_read;
   count_type      upd_old, drt_old, pub_old, stl_old;
   count_type      upd_new, drt_new, pub_new, stl_new;

   assign cmd_pop  = (state_ff == B_IDLE) && !cmd_empty;
   assign load     = (state_ff == B_RMW) && (!out_valid_ff || rsp_pop);
   assign is_read  = (cmd_ff.op == OP_READ);
   assign do_write = load && cmd_ff.found && !is_read;

   // A row never written reads as zero
   assign upd_old = rd_valid_ff ? upd_rd_ff : '0;
   assign drt_old = rd_valid_ff ? drt_rd_ff : '0;
   assign pub_old = rd_valid_ff ? pub_rd_ff : '0;
   assign stl_old = rd_valid_ff ? stl_rd_ff : '0;

   assign upd_new = upd_old + CNT_W'(cmd_ff.op == OP_UPDATE);
   assign drt_new = drt_old + CNT_W'((cmd_ff.op == OP_UPDATE) && cmd_ff.dirty);
   assign pub_new = pub_old + CNT_W'(cmd_ff.op == OP_PUBLISH);
   assign stl_new = stl_old + CNT_W'(cmd_ff.op == OP_STALE);

   always_comb begin
      row_valid_in = row_valid_ff;
      if (do_write) begin
         row_valid_in[cmd_ff.slot] = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (cmd_pop) begin
               state_in = B_RMW;
            end
         end
         B_RMW: begin
            if (load) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         row_valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Counter memories: one registered read, one write
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff      <= cmd_data;
         rd_valid_ff <= row_valid_ff[cmd_data.slot];
         upd_rd_ff   <= upd_mem[cmd_data.slot];
         drt_rd_ff   <= drt_mem[cmd_data.slot];
         pub_rd_ff   <= pub_mem[cmd_data.slot];
         stl_rd_ff   <= stl_mem[cmd_data.slot];
      end
      if (do_write) begin
         upd_mem[cmd_ff.slot] <= upd_new;
         drt_mem[cmd_ff.slot] <= drt_new;
         pub_mem[cmd_ff.slot] <= pub_new;
         stl_mem[cmd_ff.slot] <= stl_new;
      end
   end

   // Counts go out only for a read that found its key
   always_ff @(posedge clock) begin
      if (load) begin
         out_found_ff <= cmd_ff.found;
         out_upd_ff   <= (is_read && cmd_ff.found) ? upd_old : '0;
         out_drt_ff   <= (is_read && cmd_ff.found) ? drt_old : '0;
         out_pub_ff   <= (is_read && cmd_ff.found) ? pub_old : '0;
         out_stl_ff   <= (is_read && cmd_ff.found) ? stl_old : '0;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_found     = out_found_ff;
   assign rsp_updates   = out_upd_ff;
   assign rsp_dirty     = out_drt_ff;
   assign rsp_publishes = out_pub_ff;
   assign rsp_stale     = out_stl_ff;

   a_result_from_rmw: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == B_RMW))
      else $error("result appeared without a read-modify-write");

endmodule

// ----- hdl/keyed_event_counter_table.sv -----
// Keyed event counter table: fully associative slots keyed by surface id.
// Items pass through the front's compare and claim pair, the command queue and
// the back's counter read-modify-write. Each part takes a new item only once it
// has passed on the last one, and the two parts overlap.
// Reset: synchronous; slot and counter-row valid bits clear at once, no sweep.
module keyed_event_counter_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_surface_id,
   input  logic        req_dirty_flag,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_found,
   output logic [63:0] rsp_updates_count,
   output logic [63:0] rsp_dirty_count,
   output logic [63:0] rsp_publishes_count,
   output logic [63:0] rsp_stale_count
);
   import kect_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cmd_type q_in;
   cmd_type q_out;

   kect_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_op    (op_type'(req_op)),
      .req_key   (key_type'(req_surface_id)),
      .req_dirty (req_dirty_flag),
      .cmd_push  (q_push),
      .cmd_data  (q_in),
      .cmd_full  (q_full)
   );

   kect_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   kect_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (q_empty),
      .cmd_data      (q_out),
      .cmd_pop       (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_found     (rsp_found),
      .rsp_updates   (rsp_updates_count),
      .rsp_dirty     (rsp_dirty_count),
      .rsp_publishes (rsp_publishes_count),
      .rsp_stale     (rsp_stale_count)
   );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for keyed_event_counter_table: drives update, publish,
// stale and read items, predicts each result and compares the result ports.
// Depends on kect_pkg and the keyed_event_counter_table RTL.
`timescale 1ns / 100ps

module tb;
   import kect_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int KEY_POOL    = 48;

   typedef struct packed {
      logic      found;
      count_type updates;
      count_type dirties;
      count_type publishes;
      count_type stales;
   } event_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_op = OP_UPDATE;
   logic [31:0] req_surface_id = '0;
   logic        req_dirty_flag = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_found;
   logic [63:0] rsp_updates_count;
   logic [63:0] rsp_dirty_count;
   logic [63:0] rsp_publishes_count;
   logic [63:0] rsp_stale_count;

   // Predicted slot state
   logic      slot_taken [SLOT_COUNT];
   key_type   slot_owner [SLOT_COUNT];
   count_type upd_tally  [SLOT_COUNT];
   count_type dirty_tally[SLOT_COUNT];
   count_type pub_tally  [SLOT_COUNT];
   count_type stale_tally[SLOT_COUNT];
   int        slots_claimed = 0;

   event_result_type expected_counts[$];
   key_type          key_pool[KEY_POOL];

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int fail_count    = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int read_hits     = 0;
   int key_misses    = 0;
   int dropped_updates = 0;

   keyed_event_counter_table u_top (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_op              (req_op),
      .req_surface_id      (req_surface_id),
      .req_dirty_flag      (req_dirty_flag),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_found           (rsp_found),
      .rsp_updates_count   (rsp_updates_count),
      .rsp_dirty_count     (rsp_dirty_count),
      .rsp_publishes_count (rsp_publishes_count),
      .rsp_stale_count     (rsp_stale_count)
   );

   always #4 clock = ~clock;

   function automatic int lookup_slot(key_type key);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_taken[i] && slot_owner[i] == key) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Apply one item to the predicted table and return the result it produces
   function automatic event_result_type apply_event(op_type op, key_type key, logic dirty);
      event_result_type res;
      int               hit;
      res = '0;
      hit = lookup_slot(key);
      if (hit < 0 && op == OP_UPDATE) begin
         // claim the lowest free slot, if any
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!slot_taken[i] && hit < 0) begin
               hit = i;
            end
         end
         if (hit >= 0) begin
            slot_taken[hit] = 1'b1;
            slot_owner[hit] = key;
            slots_claimed++;
         end else begin
            dropped_updates++;
         end
      end
      if (hit < 0) begin
         key_misses++;
         return res;
      end
      res.found = 1'b1;
      case (op)
         OP_UPDATE: begin
            upd_tally[hit] = upd_tally[hit] + 1;
            if (dirty) begin
               dirty_tally[hit] = dirty_tally[hit] + 1;
            end
         end
         OP_PUBLISH: pub_tally[hit] = pub_tally[hit] + 1;
         OP_STALE:   stale_tally[hit] = stale_tally[hit] + 1;
         default: begin
            res.updates   = upd_tally[hit];
            res.dirties   = dirty_tally[hit];
            res.publishes = pub_tally[hit];
            res.stales    = stale_tally[hit];
            read_hits++;
         end
      endcase
      return res;
   endfunction

   task automatic send_item(input op_type op, input key_type key, input logic dirty);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_op         <= op;
      req_surface_id <= key;
      req_dirty_flag <= dirty;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_counts.push_back(apply_event(op, key, dirty));
      items_sent++;
   endtask

   // Hold the sender until every predicted result has been popped
   task automatic wait_for_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_counts.size() != 0) @(posedge clock);
   endtask

   function automatic op_type pick_op();
      int roll;
      roll = $urandom_range(99);
      if (roll < 35) return OP_UPDATE;
      if (roll < 55) return OP_PUBLISH;
      if (roll < 70) return OP_STALE;
      return OP_READ;
   endfunction

   function automatic key_type fresh_key();
      key_type key;
      key = $urandom;
      while (lookup_slot(key) >= 0) key = $urandom;
      return key;
   endfunction

   // Receiver: random stalls, plus a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_pop   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   task automatic check_field(input string name, input count_type exp_val,
                              input count_type got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      event_result_type exp_res;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_counts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual found=%0b", $time, rsp_found);
            fail_count++;
         end else begin
            exp_res = expected_counts.pop_front();
            results_seen++;
            check_field("found", count_type'(exp_res.found), count_type'(rsp_found));
            check_field("updates_count", exp_res.updates, rsp_updates_count);
            check_field("dirty_count", exp_res.dirties, rsp_dirty_count);
            check_field("publishes_count", exp_res.publishes, rsp_publishes_count);
            check_field("stale_count", exp_res.stales, rsp_stale_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_counts.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Edge keys, misses on an empty table, ignored dirty flag, counts on every op
   task automatic test_directed();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      send_item(OP_READ,    32'h0000_0000, 1'b0);
      send_item(OP_PUBLISH, 32'h0000_0000, 1'b0);
      send_item(OP_STALE,   32'hFFFF_FFFF, 1'b1);
      send_item(OP_UPDATE,  32'h0000_0000, 1'b0);
      send_item(OP_UPDATE,  32'h0000_0000, 1'b1);
      send_item(OP_UPDATE,  32'hFFFF_FFFF, 1'b1);
      send_item(OP_PUBLISH, 32'h0000_0000, 1'b1);
      send_item(OP_STALE,   32'h0000_0000, 1'b0);
      send_item(OP_STALE,   32'hFFFF_FFFF, 1'b1);
      send_item(OP_READ,    32'h0000_0000, 1'b1);
      send_item(OP_READ,    32'hFFFF_FFFF, 1'b0);
      send_item(OP_UPDATE,  32'h8000_0001, 1'b0);
      send_item(OP_READ,    32'h8000_0001, 1'b0);
      send_item(OP_READ,    32'h0000_0001, 1'b0);
      send_item(OP_PUBLISH, 32'h7FFF_FFFF, 1'b0);
      send_item(OP_READ,    32'hFFFF_FFFE, 1'b1);
      wait_for_results();
   endtask

   // Updates stay on the key pool so the table does not fill before the end
   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      op_type  op;
      key_type key;
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         op = pick_op();
         if (op == OP_UPDATE || $urandom_range(99) < 80) begin
            key = key_pool[$urandom_range(KEY_POOL - 1)];
         end else begin
            key = $urandom;
         end
         send_item(op, key, 1'($urandom_range(1)));
      end
      wait_for_results();
   endtask

   // Stall the receiver for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      hold_requests <= hold_requests + 1;
      for (int n = 0; n < 60; n++) begin
         send_item(pick_op(), key_pool[$urandom_range(KEY_POOL - 1)], 1'($urandom_range(1)));
      end
      wait_for_results();
   endtask

   // Fill every slot, then check that new keys are dropped and old ones still count
   task automatic test_full_table();
      op_type op;
      send_idle_pct = 36;
      pop_stall_pct = 36;
      while (slots_claimed < SLOT_COUNT) begin
         send_item(OP_UPDATE, fresh_key(), 1'($urandom_range(1)));
      end
      for (int n = 0; n < 40; n++) begin
         op = pick_op();
         if ($urandom_range(1) == 0) begin
            send_item(op, fresh_key(), 1'($urandom_range(1)));
         end else begin
            send_item(op, slot_owner[$urandom_range(SLOT_COUNT - 1)], 1'($urandom_range(1)));
         end
      end
      wait_for_results();
   endtask

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_taken[i]  = 1'b0;
         slot_owner[i]  = '0;
         upd_tally[i]   = '0;
         dirty_tally[i] = '0;
         pub_tally[i]   = '0;
         stale_tally[i] = '0;
      end
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < KEY_POOL; i++) begin
         key_pool[i] = $urandom;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(400, 0, 0);
      test_random_traffic(400, 67, 0);
      test_random_traffic(400, 0, 67);
      test_backpressure();
      test_random_traffic(400, 36, 36);
      test_full_table();

      repeat (16) @(posedge clock);
      $display("Ran %0d items through %0d checked results: %0d read hits, %0d key misses,",
               items_sent, results_seen, read_hits, key_misses);
      $display("%0d updates dropped on a full table, with idle, stall and hold-off phases.",
               dropped_updates);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- keyed_event_counter_table.f -----
hdl/kect_pkg.sv
hdl/kect_front.sv
hdl/kect_queue.sv
hdl/kect_back.sv
hdl/keyed_event_counter_table.sv
tb/sv/tb.sv
